[hw/rtl/itp_pkg.sv]
// types, character codes and helper functions for the infix to postfix converter
`default_nettype none
package itp_pkg;

    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] PREC_POW = 2'd3;
    localparam logic [1:0] PREC_MUL = 2'd2;
    localparam logic [1:0] PREC_ADD = 2'd1;
    localparam logic [1:0] PREC_NONE = 2'd0;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CLOSE    = 2'd1,
        ERR_OPEN     = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [7:0] sym;
        logic       sym_valid;
        t_err       error;
        logic       last;
    } t_out;

    typedef struct packed {
        logic push;
        t_out data;
    } t_emit;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_CARET:          p = PREC_POW;
            CH_STAR, CH_SLASH: p = PREC_MUL;
            CH_PLUS, CH_MINUS: p = PREC_ADD;
            default:           p = PREC_NONE;
        endcase
        return p;
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return prec_of(c) != PREC_NONE;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/itp_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/itp_seq.sv]
// sequencer: operator stack control, precedence compare and result ordering
`default_nettype none
module itp_seq #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire itp_pkg::t_in                   i_in,
    output itp_pkg::t_emit                      o_emit,
    input  wire logic                           i_out_free,
    output logic                                o_ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]      o_ram_waddr,
    output logic [7:0]                          o_ram_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [7:0]                     i_ram_rdata
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    itp_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    itp_pkg::t_out   r_pend, n_pend;
    logic            r_pend_v, n_pend_v;
    logic            r_open, n_open;
    logic            r_mode;
    logic [7:0]      r_ch;

    logic [CW-1:0]   cnt_m1;
    logic            has_top;
    logic            full;
    logic [7:0]      top;
    logic            act_emit, act_final, act_end, act_pop, act_push;
    logic            act_set_open, act_clr_open;
    itp_pkg::t_out   act_res;
    logic            push_req;
    itp_pkg::t_out   push_data;
    logic            stall;

    assign cnt_m1      = r_count - CW'(1);
    assign has_top     = r_count != '0;
    assign full        = r_count == CW'(STACK_DEPTH);
    assign top         = i_ram_rdata;
    assign o_ram_raddr = cnt_m1[AW-1:0];
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itp_pkg::S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_open   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_open   <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_in.mode;
            r_ch   <= i_in.ch;
        end
    end

    // decode of the current request against the stack top
    always_comb begin
        act_emit     = 1'b0;
        act_final    = 1'b0;
        act_end      = 1'b0;
        act_pop      = 1'b0;
        act_push     = 1'b0;
        act_set_open = 1'b0;
        act_clr_open = 1'b0;
        act_res      = '{sym: 8'd0, sym_valid: 1'b0, error: itp_pkg::ERR_NONE, last: 1'b0};
        if (r_mode) begin
            if (has_top) begin
                act_pop = 1'b1;
                if (top == itp_pkg::CH_LPAR) begin
                    act_set_open = 1'b1;
                end else begin
                    act_emit = 1'b1;
                    act_res.sym = top;
                    act_res.sym_valid = 1'b1;
                end
            end else begin
                act_emit = 1'b1;
                act_final = 1'b1;
                act_clr_open = 1'b1;
                if (r_open) begin
                    act_res.error = itp_pkg::ERR_OPEN;
                end
            end
        end else if (r_ch == itp_pkg::CH_LPAR || itp_pkg::is_operator(r_ch)) begin
            if (itp_pkg::is_operator(r_ch) && has_top &&
                itp_pkg::prec_of(top) >= itp_pkg::prec_of(r_ch)) begin
                act_pop = 1'b1;
                act_emit = 1'b1;
                act_res.sym = top;
                act_res.sym_valid = 1'b1;
            end else if (full) begin
                act_emit = 1'b1;
                act_final = 1'b1;
                act_res.error = itp_pkg::ERR_OVERFLOW;
            end else begin
                act_push = 1'b1;
                act_end = 1'b1;
            end
        end else if (r_ch == itp_pkg::CH_RPAR) begin
            if (has_top) begin
                act_pop = 1'b1;
                if (top == itp_pkg::CH_LPAR) begin
                    act_end = 1'b1;
                end else begin
                    act_emit = 1'b1;
                    act_res.sym = top;
                    act_res.sym_valid = 1'b1;
                end
            end else begin
                act_emit = 1'b1;
                act_final = 1'b1;
                act_res.error = itp_pkg::ERR_CLOSE;
            end
        end else begin
            act_emit = 1'b1;
            act_final = 1'b1;
            act_res.sym = r_ch;
            act_res.sym_valid = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_open     = r_open;
        o_in_ready = 1'b0;
        o_ram_we   = 1'b0;
        push_req   = 1'b0;
        push_data  = r_pend;
        push_data.last = 1'b0;
        stall      = 1'b0;
        o_emit     = '0;

        case (r_state)
            itp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = itp_pkg::S_WORK;
                end
            end
            itp_pkg::S_WORK: begin
                if (act_emit && !act_final) begin
                    push_req = r_pend_v;
                end else if (act_emit) begin
                    push_req = 1'b1;
                    if (!r_pend_v) begin
                        push_data = act_res;
                        push_data.last = 1'b1;
                    end
                end else if (act_end) begin
                    push_req = r_pend_v;
                    push_data.last = 1'b1;
                end
                stall = push_req && !i_out_free;
                if (!stall) begin
                    o_emit.push = push_req;
                    o_emit.data = push_data;
                    if (act_pop) begin
                        n_count = cnt_m1;
                    end
                    if (act_push) begin
                        o_ram_we = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    if (act_set_open) begin
                        n_open = 1'b1;
                    end
                    if (act_clr_open) begin
                        n_open = 1'b0;
                    end
                    if (act_emit && !act_final) begin
                        n_pend = act_res;
                        n_pend_v = 1'b1;
                        n_state = itp_pkg::S_WAIT;
                    end else if (act_emit) begin
                        if (r_pend_v) begin
                            n_pend = act_res;
                            n_state = itp_pkg::S_FIN;
                        end else begin
                            n_state = itp_pkg::S_IDLE;
                        end
                    end else if (act_end) begin
                        n_pend_v = 1'b0;
                        n_state = itp_pkg::S_IDLE;
                    end else begin
                        n_state = itp_pkg::S_WAIT;
                    end
                end
            end
            itp_pkg::S_WAIT: begin
                n_state = itp_pkg::S_WORK;
            end
            itp_pkg::S_FIN: begin
                if (i_out_free) begin
                    o_emit.push = 1'b1;
                    o_emit.data = r_pend;
                    o_emit.data.last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = itp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/infix_to_postfix_converter.sv]
// top level: infix to postfix converter with operator stack ram and output register
// an accepted operand passes from the request register through the work state into the output register
// a new request is taken only once the previous one is finished and the sequencer is idle again;
// stack pops, a final result after an emitted operator and output stalls all lengthen a request
// reset (synchronous, active low) empties the stack and clears the output valid flag
// stack ram contents are not cleared; only entries below the count are ever used
`default_nettype none
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire itp_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output itp_pkg::t_out       o_data
);

    localparam int AW = $clog2(STACK_DEPTH);

    itp_pkg::t_emit  emit;
    logic            out_free;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            r_out_valid;
    itp_pkg::t_out   r_out;

    assign out_free = !r_out_valid || i_ready;

    itp_seq #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_in        (i_data),
        .o_emit      (emit),
        .i_out_free  (out_free),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    itp_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.push) begin
            r_out <= emit.data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

[test/infix_to_postfix_converter_tb.sv]
// testbench for the infix to postfix converter: directed and random requests checked against a stack model
`timescale 1ns / 1ps
module infix_to_postfix_converter_tb;

    localparam int STACK_DEPTH = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 450;

    class postfix_scoreboard;
        logic [7:0]     op_stack [STACK_DEPTH];
        int unsigned    op_count;
        itp_pkg::t_out  postfix_q[$];
        itp_pkg::t_out  batch[$];
        int unsigned    mismatches;

        function new();
            op_count = 0;
            mismatches = 0;
        endfunction

        function logic [1:0] rank(logic [7:0] c);
            case (c)
                itp_pkg::CH_CARET:                   return itp_pkg::PREC_POW;
                itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return itp_pkg::PREC_MUL;
                itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return itp_pkg::PREC_ADD;
                default:                             return itp_pkg::PREC_NONE;
            endcase
        endfunction

        function void emit(logic [7:0] sym, logic sym_valid, itp_pkg::t_err err);
            itp_pkg::t_out r;
            r.sym = sym;
            r.sym_valid = sym_valid;
            r.error = err;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        function void convert(itp_pkg::t_in req);
            logic [7:0] top;
            logic       open_seen;
            logic       matched;
            logic [1:0] p;
            batch.delete();
            if (req.mode) begin
                open_seen = 1'b0;
                while (op_count > 0) begin
                    op_count--;
                    top = op_stack[op_count];
                    if (top == itp_pkg::CH_LPAR) open_seen = 1'b1;
                    else emit(top, 1'b1, itp_pkg::ERR_NONE);
                end
                if (open_seen) emit(8'h00, 1'b0, itp_pkg::ERR_OPEN);
                else emit(8'h00, 1'b0, itp_pkg::ERR_NONE);
            end else if (req.ch == itp_pkg::CH_LPAR || rank(req.ch) != itp_pkg::PREC_NONE) begin
                p = rank(req.ch);
                if (req.ch != itp_pkg::CH_LPAR) begin
                    while (op_count > 0 && rank(op_stack[op_count - 1]) >= p) begin
                        op_count--;
                        emit(op_stack[op_count], 1'b1, itp_pkg::ERR_NONE);
                    end
                end
                if (op_count >= STACK_DEPTH) begin
                    emit(8'h00, 1'b0, itp_pkg::ERR_OVERFLOW);
                end else begin
                    op_stack[op_count] = req.ch;
                    op_count++;
                end
            end else if (req.ch == itp_pkg::CH_RPAR) begin
                matched = 1'b0;
                while (op_count > 0 && !matched) begin
                    op_count--;
                    top = op_stack[op_count];
                    if (top == itp_pkg::CH_LPAR) matched = 1'b1;
                    else emit(top, 1'b1, itp_pkg::ERR_NONE);
                end
                if (!matched) emit(8'h00, 1'b0, itp_pkg::ERR_CLOSE);
            end else begin
                emit(req.ch, 1'b1, itp_pkg::ERR_NONE);
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) postfix_q.push_back(batch[i]);
        endfunction

        function void check_symbol(itp_pkg::t_out got);
            itp_pkg::t_out want;
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = postfix_q.pop_front();
            if (got.sym !== want.sym) begin
                $display("%0t: sym mismatch, expected %h, actual %h", $time, want.sym, got.sym);
                mismatches++;
            end
            if (got.sym_valid !== want.sym_valid) begin
                $display("%0t: sym_valid mismatch, expected %b, actual %b",
                         $time, want.sym_valid, got.sym_valid);
                mismatches++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error mismatch, expected %0d, actual %0d",
                         $time, want.error, got.error);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    itp_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    itp_pkg::t_out o_data;

    postfix_scoreboard sb;
    itp_pkg::t_in stim_q[$];
    bit  calm;
    int  idle_cycles;

    infix_to_postfix_converter u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_item(logic mode, logic [7:0] ch);
        itp_pkg::t_in r;
        r.mode = mode;
        r.ch = ch;
        stim_q.push_back(r);
    endfunction

    function automatic logic [7:0] any_op();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CH_CARET;
            1:       return itp_pkg::CH_STAR;
            2:       return itp_pkg::CH_SLASH;
            3:       return itp_pkg::CH_PLUS;
            default: return itp_pkg::CH_MINUS;
        endcase
    endfunction

    function automatic logic [7:0] any_operand();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0 || c == itp_pkg::CH_LPAR || c == itp_pkg::CH_RPAR ||
            c == itp_pkg::CH_CARET || c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH ||
            c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end
        return c;
    endfunction

    function automatic void add_expr(int unsigned depth);
        int unsigned terms;
        terms = $urandom_range(1, 4);
        for (int unsigned i = 0; i < terms; i++) begin
            if (i > 0) add_item(1'b0, any_op());
            if (depth < 3 && $urandom_range(0, 3) == 0) begin
                add_item(1'b0, itp_pkg::CH_LPAR);
                add_expr(depth + 1);
                add_item(1'b0, itp_pkg::CH_RPAR);
            end else begin
                add_item(1'b0, any_operand());
            end
        end
    endfunction

    function automatic void add_deep_nest();
        int unsigned n;
        n = $urandom_range(28, 36);
        repeat (n) begin
            add_item(1'b0, itp_pkg::CH_LPAR);
            if ($urandom_range(0, 1) == 1) begin
                add_item(1'b0, any_operand());
                add_item(1'b0, any_op());
            end
        end
        add_item(1'b0, any_operand());
        repeat ($urandom_range(0, 6)) add_item(1'b0, itp_pkg::CH_RPAR);
        add_item(1'b1, 8'($urandom));
    endfunction

    task automatic send_request(input itp_pkg::t_in req);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        do @(posedge i_clk); while (!o_ready);
        sb.convert(req);
    endtask

    // result side: random stalls
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_symbol(o_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned kind;
        sb = new();
        calm = 1'b0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;

        // all operators and precedence pops
        add_item(1'b0, "a");
        add_item(1'b0, itp_pkg::CH_PLUS);
        add_item(1'b0, "b");
        add_item(1'b0, itp_pkg::CH_STAR);
        add_item(1'b0, "c");
        add_item(1'b0, itp_pkg::CH_CARET);
        add_item(1'b0, "d");
        add_item(1'b0, itp_pkg::CH_MINUS);
        add_item(1'b0, "e");
        add_item(1'b0, itp_pkg::CH_SLASH);
        add_item(1'b0, "f");
        add_item(1'b1, itp_pkg::CH_RPAR);
        // unmatched close after popping an operator
        add_item(1'b0, itp_pkg::CH_LPAR);
        add_item(1'b0, "q");
        add_item(1'b0, itp_pkg::CH_RPAR);
        add_item(1'b0, itp_pkg::CH_PLUS);
        add_item(1'b0, itp_pkg::CH_RPAR);
        // odd operands and unclosed open
        add_item(1'b0, itp_pkg::CH_LPAR);
        add_item(1'b0, 8'h00);
        add_item(1'b0, itp_pkg::CH_PLUS);
        add_item(1'b0, 8'hFF);
        add_item(1'b0, " ");
        add_item(1'b1, 8'hFF);

        while (stim_q.size() < 23 + RANDOM_REQUESTS) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                add_expr(0);
                add_item(1'b1, 8'($urandom));
            end else if (kind < 15) begin
                repeat ($urandom_range(1, 8))
                    add_item($urandom_range(0, 7) == 0, 8'($urandom));
            end else if (kind < 17) begin
                if ($urandom_range(0, 1) == 1) add_item(1'b0, itp_pkg::CH_LPAR);
                add_expr(0);
                if ($urandom_range(0, 1) == 1) add_item(1'b0, itp_pkg::CH_RPAR);
                else add_item(1'b0, any_op());
                add_item(1'b1, 8'($urandom));
            end else if (kind < 19) begin
                add_expr(0);
            end else begin
                add_deep_nest();
            end
        end
        add_item(1'b1, 8'($urandom));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_q[i]) begin
            calm = (i + 60 >= stim_q.size());
            send_request(stim_q[i]);
        end
        i_valid <= 1'b0;

        while (sb.postfix_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.postfix_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
